[rtl/core/bole_pkg.sv]
`timescale 1ns / 1ps

package bole_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int DATA_W       = 32;
  localparam int POS_W        = 8;
  localparam int ENTRIES_W    = 5;

  typedef enum logic [2:0] {
    OP_CLEAR      = 3'd0,
    OP_INS_HEAD   = 3'd1,
    OP_INS_POS    = 3'd2,
    OP_INS_TAIL   = 3'd3,
    OP_DEL_HEAD   = 3'd4,
    OP_DEL_POS    = 3'd5,
    OP_DEL_TAIL   = 3'd6,
    OP_READ_ALL   = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_BADPOS = 2'd2,
    STAT_EMPTY  = 2'd3
  } status_t;

  // What one cell loads at the next edge.
  typedef enum logic [2:0] {
    CM_HOLD,
    CM_NEW,
    CM_LEFT,
    CM_RIGHT,
    CM_HEAD
  } cell_mode_t;

  // What the whole chain does in the current cycle.
  typedef enum logic [1:0] {
    CK_HOLD,
    CK_INSERT,
    CK_DELETE,
    CK_ROTATE
  } chain_kind_t;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

endpackage

[rtl/core/bole_cell.sv]
`timescale 1ns / 1ps

module bole_cell (
  input  logic                              clk,
  input  bole_pkg::cell_mode_t              mode,
  input  logic [bole_pkg::DATA_W-1:0]       left_val,
  input  logic [bole_pkg::DATA_W-1:0]       right_val,
  input  logic [bole_pkg::DATA_W-1:0]       head_val,
  input  logic [bole_pkg::DATA_W-1:0]       new_val,
  output logic [bole_pkg::DATA_W-1:0]       value
);

  logic [bole_pkg::DATA_W-1:0] value_r;
  logic [bole_pkg::DATA_W-1:0] value_nxt;

  always_comb begin
    unique case (mode)
      bole_pkg::CM_HOLD:  value_nxt = value_r;
      bole_pkg::CM_NEW:   value_nxt = new_val;
      bole_pkg::CM_LEFT:  value_nxt = left_val;
      bole_pkg::CM_RIGHT: value_nxt = right_val;
      bole_pkg::CM_HEAD:  value_nxt = head_val;
      default:            value_nxt = value_r;
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;

endmodule

[rtl/core/bounded_ordered_list_engine_core.sv]
`timescale 1ns / 1ps
// A result is registered: it is in the output register in the cycle after its item is taken.
// Edits may follow back to back while the output is not stalled and no read all is running.
// A read all on a list of N entries is accepted without a beat and then gives
// one beat per entry, as the cell chain rotates by one place per beat.
// Reset (synchronous, rst_n low) empties the list and drops the output beat;
// the cell contents are left as they are.
module bounded_ordered_list_engine_core #(
  parameter int CAPACITY = bole_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [2:0]                          in_operation,
  input  logic [bole_pkg::POS_W-1:0]          in_position,
  input  logic signed [bole_pkg::DATA_W-1:0]  in_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          out_status,
  output logic signed [bole_pkg::DATA_W-1:0]  out_value_out,
  output logic                                out_last,
  output logic [bole_pkg::ENTRIES_W-1:0]      out_entries_now
);

  // The count must be able to hold CAPACITY itself.
  localparam int CNT_W = $clog2(CAPACITY + 1);
  // Positions are compared one bit wider so that count + 1 never wraps.
  localparam int CMP_W = bole_pkg::POS_W + 1;
  localparam int DW    = bole_pkg::DATA_W;

  // Control state.
  bole_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] rd_left_r, rd_left_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Output beat register (payload, no reset).
  logic [1:0]               out_status_r, out_status_nxt;
  logic [DW-1:0]            out_value_r, out_value_nxt;
  logic                     out_last_r, out_last_nxt;
  logic [CNT_W-1:0]         out_cnt_r, out_cnt_nxt;

  logic slot_free;
  logic accept;
  logic out_load;

  // Decoded edit for the item on the input port.
  bole_pkg::op_t         op;
  bole_pkg::status_t     ed_status;
  logic                  ed_take;
  logic [CNT_W-1:0]      ed_cnt;
  bole_pkg::chain_kind_t ed_kind;
  logic [CNT_W-1:0]      ed_idx;
  logic                  ed_go_read;

  logic [CMP_W-1:0]         pos_ext;
  logic [CMP_W-1:0]         cnt_ext;
  logic [bole_pkg::POS_W-1:0] pos_m1;
  logic                     list_full;
  logic                     list_empty;

  // What the chain does this cycle.
  bole_pkg::chain_kind_t chain_kind;
  logic [CNT_W-1:0]      chain_idx;

  bole_pkg::cell_mode_t cell_mode [CAPACITY];
  logic [DW-1:0]        cell_val  [CAPACITY];
  logic [DW-1:0]        cell_pick [CAPACITY];
  logic [DW-1:0]        picked_val;

  assign op         = bole_pkg::op_t'(in_operation);
  assign list_full  = (count_r == CNT_W'(CAPACITY));
  assign list_empty = (count_r == '0);
  assign pos_ext    = CMP_W'(in_position);
  assign cnt_ext    = CMP_W'(count_r);
  assign pos_m1     = in_position - 1'b1;

  // The output register can take a new beat when it is empty or being drained.
  assign slot_free = !out_valid_r || !out_stall;
  assign accept    = in_valid && !in_stall;

  // ------------------------------------------------------------------
  // Edit decode. For each edit the status, the new count and the
  // shift the chain must make are all worked out here.
  // The position checks follow the full and empty checks, as specified.
  // ------------------------------------------------------------------
  always_comb begin
    ed_status  = bole_pkg::STAT_OK;
    ed_take    = 1'b0;
    ed_cnt     = count_r;
    ed_kind    = bole_pkg::CK_HOLD;
    ed_idx     = '0;
    ed_go_read = 1'b0;
    unique case (op)
      bole_pkg::OP_CLEAR: begin
        ed_cnt = '0;
      end
      bole_pkg::OP_INS_HEAD, bole_pkg::OP_INS_POS, bole_pkg::OP_INS_TAIL: begin
        if (list_full) begin
          ed_status = bole_pkg::STAT_FULL;
        end else if (op == bole_pkg::OP_INS_POS &&
                     (in_position == '0 || pos_ext > cnt_ext + 1'b1)) begin
          ed_status = bole_pkg::STAT_BADPOS;
        end else begin
          ed_kind = bole_pkg::CK_INSERT;
          ed_cnt  = count_r + 1'b1;
          priority case (op)
            bole_pkg::OP_INS_HEAD: ed_idx = '0;
            bole_pkg::OP_INS_TAIL: ed_idx = count_r;
            default:               ed_idx = CNT_W'(pos_m1);
          endcase
        end
      end
      bole_pkg::OP_DEL_HEAD, bole_pkg::OP_DEL_POS, bole_pkg::OP_DEL_TAIL: begin
        if (list_empty) begin
          ed_status = bole_pkg::STAT_EMPTY;
        end else if (op == bole_pkg::OP_DEL_POS &&
                     (in_position == '0 || pos_ext > cnt_ext)) begin
          ed_status = bole_pkg::STAT_BADPOS;
        end else begin
          ed_kind = bole_pkg::CK_DELETE;
          ed_take = 1'b1;
          ed_cnt  = count_r - 1'b1;
          priority case (op)
            bole_pkg::OP_DEL_HEAD: ed_idx = '0;
            bole_pkg::OP_DEL_TAIL: ed_idx = count_r - 1'b1;
            default:               ed_idx = CNT_W'(pos_m1);
          endcase
        end
      end
      bole_pkg::OP_READ_ALL: begin
        // An empty list answers at once; otherwise the beats come from the
        // read state, one per cycle while the output is not stalled.
        if (list_empty) begin
          ed_status = bole_pkg::STAT_EMPTY;
        end else begin
          ed_go_read = 1'b1;
        end
      end
      default: begin
        ed_status = bole_pkg::STAT_OK;
      end
    endcase
  end

  // ------------------------------------------------------------------
  // Sequencer: next state.
  // ------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bole_pkg::S_IDLE: begin
        if (accept && ed_go_read) begin
          state_nxt = bole_pkg::S_READ;
        end
      end
      bole_pkg::S_READ: begin
        if (slot_free && rd_left_r == CNT_W'(1)) begin
          state_nxt = bole_pkg::S_IDLE;
        end
      end
      default: state_nxt = bole_pkg::S_IDLE;
    endcase
  end

  // ------------------------------------------------------------------
  // Sequencer: outputs. In the idle state an accepted edit loads its
  // single beat. In the read state the head cell is shown and the chain
  // rotates by one place, so that after N beats the list is back in
  // its original order.
  // ------------------------------------------------------------------
  always_comb begin
    in_stall       = 1'b1;
    out_load       = 1'b0;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_last_nxt   = out_last_r;
    out_cnt_nxt    = out_cnt_r;
    chain_kind     = bole_pkg::CK_HOLD;
    chain_idx      = '0;
    count_nxt      = count_r;
    rd_left_nxt    = rd_left_r;
    unique case (state_r)
      bole_pkg::S_IDLE: begin
        in_stall = !slot_free;
        if (accept) begin
          count_nxt  = ed_cnt;
          chain_kind = ed_kind;
          chain_idx  = ed_idx;
          if (ed_go_read) begin
            rd_left_nxt = count_r;
          end else begin
            out_load       = 1'b1;
            out_status_nxt = ed_status;
            out_value_nxt  = ed_take ? picked_val : '0;
            out_last_nxt   = 1'b1;
            out_cnt_nxt    = ed_cnt;
          end
        end
      end
      bole_pkg::S_READ: begin
        if (slot_free) begin
          out_load       = 1'b1;
          out_status_nxt = bole_pkg::STAT_OK;
          out_value_nxt  = cell_val[0];
          out_last_nxt   = (rd_left_r == CNT_W'(1));
          out_cnt_nxt    = count_r;
          chain_kind     = bole_pkg::CK_ROTATE;
          chain_idx      = count_r - 1'b1;
          rd_left_nxt    = rd_left_r - 1'b1;
        end
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // ------------------------------------------------------------------
  // Cell chain. Every cell works out its own move from the chain's
  // command and its place in the row; all cells move in the same cycle.
  // ------------------------------------------------------------------
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CNT_W-1:0] CELL_I = CNT_W'(i);
    logic [DW-1:0] left_v;
    logic [DW-1:0] right_v;

    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_inner_l
      assign left_v = cell_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_end
      assign right_v = '0;
    end else begin : g_inner_r
      assign right_v = cell_val[i+1];
    end

    always_comb begin
      cell_mode[i] = bole_pkg::CM_HOLD;
      unique case (chain_kind)
        bole_pkg::CK_INSERT: begin
          if (CELL_I == chain_idx) begin
            cell_mode[i] = bole_pkg::CM_NEW;
          end else if (CELL_I > chain_idx) begin
            cell_mode[i] = bole_pkg::CM_LEFT;
          end
        end
        bole_pkg::CK_DELETE: begin
          if (CELL_I >= chain_idx) begin
            cell_mode[i] = bole_pkg::CM_RIGHT;
          end
        end
        bole_pkg::CK_ROTATE: begin
          // The tail cell takes the head value, the cells before it move up by one.
          if (CELL_I == chain_idx) begin
            cell_mode[i] = bole_pkg::CM_HEAD;
          end else if (CELL_I < chain_idx) begin
            cell_mode[i] = bole_pkg::CM_RIGHT;
          end
        end
        default: cell_mode[i] = bole_pkg::CM_HOLD;
      endcase
    end

    // Only the cell at the chain index passes its value to the pick tree; a delete uses it.
    assign cell_pick[i] = (CELL_I == chain_idx) ? cell_val[i] : '0;

    bole_cell u_cell (
      .clk       (clk),
      .mode      (cell_mode[i]),
      .left_val  (left_v),
      .right_val (right_v),
      .head_val  (cell_val[0]),
      .new_val   (in_value),
      .value     (cell_val[i])
    );
  end

  // OR of the masked cell values: at most one is non-zero.
  always_comb begin
    picked_val = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      picked_val = picked_val | cell_pick[k];
    end
  end

  // ------------------------------------------------------------------
  // Registers.
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bole_pkg::S_IDLE;
      count_r     <= '0;
      rd_left_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_left_r   <= rd_left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_last_r   <= out_last_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_value_out   = out_value_r;
  assign out_last        = out_last_r;
  assign out_entries_now = bole_pkg::ENTRIES_W'(out_cnt_r);

endmodule
